// ===== hw/rtl/ddmf_pkg.sv =====
// ddmf_pkg: shared widths, defaults and register codes of the dust density median filter
// no dependencies; used by the interfaces, the top level and its checker

package ddmf_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned SCALE_W    = 11;
  localparam int unsigned OFFSET_W   = 10;
  localparam int unsigned DENSITY_W  = 18;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned SAMPLES_PER_READING_DEF = 8;
  localparam int unsigned WINDOW_SIZE_DEF         = 8;
  localparam int unsigned ADC_FULL_SCALE_DEF      = 1024;

  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 11'd1000;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd130;

  // hundredths of ug/m3 per ug/m3
  localparam int unsigned CENTI = 100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DENSITY_SCALE    = 8'd0,
    REG_ZERO_DUST_OFFSET = 8'd1
  } cfg_reg_e;

endpackage

// ===== hw/rtl/ddmf_if.sv =====
// ddmf channel interfaces: sample, result and register write channels
// depends on ddmf_pkg for payload widths

interface ddmf_sample_if;
  logic                              valid;
  logic                              ready;
  logic [ddmf_pkg::SAMPLE_W-1:0]     adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ddmf_result_if;
  logic                              valid;
  logic                              ready;
  logic [ddmf_pkg::DENSITY_W-1:0]    density_centi;
  modport source (output valid, output density_centi, input ready);
  modport sink   (input valid, input density_centi, output ready);
endinterface

interface ddmf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ddmf_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [ddmf_pkg::CFG_DATA_W-1:0]   wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hw/rtl/dust_density_median_filter.sv =====
// dust_density_median_filter: group sum, density scaling, windowed median, centi rounding
// depends on ddmf_pkg and the channel interfaces in ddmf_if.sv
// flow: a sample word is taken each cycle until a group ends; the last word of a group
//   gives its result after the rank scan of the window memory and the reciprocal multiply
//   in 16-bit steps; no samples are taken meanwhile
// reset: scale and offset registers return to defaults, window is empty; the window memory is not cleared

module dust_density_median_filter #(
  parameter int unsigned SAMPLES_PER_READING = ddmf_pkg::SAMPLES_PER_READING_DEF,
  parameter int unsigned WINDOW_SIZE         = ddmf_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned ADC_FULL_SCALE      = ddmf_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ddmf_cfg_if.sink            cfg_i,
  ddmf_sample_if.sink         sample_i,
  ddmf_result_if.source       result_o
);

  localparam longint unsigned SUM_MAX =
    longint'(SAMPLES_PER_READING) * ((longint'(1) << ddmf_pkg::SAMPLE_W) - 1);
  localparam int unsigned SUM_W = $clog2(SUM_MAX + 1);
  localparam int unsigned CNT_SPR_W = $clog2(SAMPLES_PER_READING + 1);
  localparam int unsigned RAW_W = SUM_W + ddmf_pkg::SCALE_W;
  localparam longint unsigned RAW_MAX =
    SUM_MAX * ((longint'(1) << ddmf_pkg::SCALE_W) - 1);
  localparam longint unsigned DENOM =
    longint'(ADC_FULL_SCALE) * longint'(SAMPLES_PER_READING);
  localparam int unsigned SUB_W =
    $clog2(((longint'(1) << ddmf_pkg::OFFSET_W) - 1) * DENOM + 1);
  localparam int unsigned CMP_W = (RAW_W > SUB_W) ? RAW_W : SUB_W;
  localparam int unsigned S_W = RAW_W + 1;
  localparam longint unsigned NUM_MAX = 2 * RAW_MAX * ddmf_pkg::CENTI + DENOM;
  localparam int unsigned NUM_W = $clog2(NUM_MAX + 1);
  localparam longint unsigned DIVISOR = 2 * DENOM;
  localparam int unsigned DIV_W = $clog2(DIVISOR + 1);
  // quotient by multiplying with a rounded-up reciprocal, exact for every numerator
  localparam int unsigned DIV_SH = NUM_W + DIV_W;
  localparam longint unsigned RECIP = ((longint'(1) << DIV_SH) + DIVISOR - 1) / DIVISOR;
  localparam int unsigned RCP_W = $clog2(RECIP + 1);
  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned N_CHUNK = (RCP_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned RCP_PAD_W = N_CHUNK * CHUNK_W;
  localparam int unsigned ACC_W = NUM_W + RCP_PAD_W;
  localparam int unsigned PART_W = NUM_W + CHUNK_W;
  localparam int unsigned DC_W = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;
  localparam int unsigned IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_WRITE = 9'b000000100,
    ST_SCAN  = 9'b000001000,
    ST_LAST  = 9'b000010000,
    ST_PICK  = 9'b000100000,
    ST_SUM   = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [ddmf_pkg::SCALE_W-1:0]  scale_q;
  logic [ddmf_pkg::OFFSET_W-1:0] offset_q;

  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_SPR_W-1:0] cnt_q, cnt_d;
  logic [RAW_W-1:0]     prod_q, prod_d;
  logic [SUB_W-1:0]     sub_q, sub_d;
  logic [IDX_W-1:0]     wp_q, wp_d;
  logic                 full_q, full_d;
  logic [IDX_W-1:0]     nm1_q, nm1_d;
  logic [CNT_W-1:0]     klo_q, klo_d, khi_q, khi_d;
  logic [IDX_W-1:0]     i_q, i_d, j_q, j_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0]     lt_q, lt_d, le_q, le_d;
  logic [RAW_W-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [RCP_PAD_W-1:0] rcp_q, rcp_d;
  logic [DC_W-1:0]      dc_q, dc_d;
  logic                 res_vld_q, res_vld_d;
  logic [ddmf_pkg::DENSITY_W-1:0] res_q, res_d;

  logic [RAW_W-1:0] win_mem [WINDOW_SIZE];
  logic [RAW_W-1:0] cand_q, rdb_q;
  logic             mem_we;
  logic [RAW_W-1:0] raw;
  logic [CMP_W-1:0] prod_x, sub_x;
  logic [S_W-1:0]   sum_s;
  logic [PART_W-1:0] part;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ddmf_pkg::SCALE_RESET;
      offset_q <= ddmf_pkg::OFFSET_RESET;
    end else if (cfg_i.valid) begin
      unique case (ddmf_pkg::cfg_reg_e'(cfg_i.reg_index))
        ddmf_pkg::REG_DENSITY_SCALE: begin
          scale_q <= cfg_i.wdata[ddmf_pkg::SCALE_W-1:0];
        end
        ddmf_pkg::REG_ZERO_DUST_OFFSET: begin
          offset_q <= cfg_i.wdata[ddmf_pkg::OFFSET_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // window memory, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[wp_q] <= raw;
    end
    cand_q <= win_mem[i_q];
    rdb_q  <= win_mem[j_q];
  end

  assign prod_x = CMP_W'(prod_q);
  assign sub_x  = CMP_W'(sub_q);
  assign raw    = (prod_x > sub_x) ? RAW_W'(prod_x - sub_x) : '0;
  assign sum_s  = S_W'(lo_q) + S_W'(hi_q);
  assign part   = PART_W'(num_q) * PART_W'(rcp_q[RCP_PAD_W-1 -: CHUNK_W]);

  assign sample_i.ready         = (state_q == ST_IDLE);
  assign result_o.valid         = res_vld_q;
  assign result_o.density_centi = res_q;

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    sub_d     = sub_q;
    wp_d      = wp_q;
    full_d    = full_q;
    nm1_d     = nm1_q;
    klo_d     = klo_q;
    khi_d     = khi_q;
    i_d       = i_q;
    j_d       = j_q;
    cmp_vld_d = 1'b0;
    lt_d      = lt_q;
    le_d      = le_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    num_d     = num_q;
    acc_d     = acc_q;
    rcp_d     = rcp_q;
    dc_d      = dc_q;
    res_d     = res_q;
    res_vld_d = res_vld_q & ~result_o.ready;
    mem_we    = 1'b0;

    if (cmp_vld_q) begin
      lt_d = lt_q + CNT_W'(rdb_q < cand_q);
      le_d = le_q + CNT_W'(rdb_q <= cand_q);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          sum_d = sum_q + SUM_W'(sample_i.adc_sample);
          if (cnt_q == CNT_SPR_W'(SAMPLES_PER_READING - 1)) begin
            cnt_d   = '0;
            state_d = ST_MUL;
          end else begin
            cnt_d = cnt_q + CNT_SPR_W'(1);
          end
        end
      end
      ST_MUL: begin
        prod_d  = RAW_W'(sum_q) * RAW_W'(scale_q);
        sub_d   = SUB_W'(offset_q) * SUB_W'(DENOM);
        sum_d   = '0;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        if (wp_q == IDX_W'(WINDOW_SIZE - 1)) begin
          wp_d   = '0;
          full_d = 1'b1;
        end else begin
          wp_d = wp_q + IDX_W'(1);
        end
        nm1_d   = (full_d) ? IDX_W'(WINDOW_SIZE - 1) : wp_q;
        klo_d   = CNT_W'(nm1_d) >> 1;
        khi_d   = (CNT_W'(nm1_d) + CNT_W'(1)) >> 1;
        i_d     = '0;
        j_d     = '0;
        lt_d    = '0;
        le_d    = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmp_vld_d = 1'b1;
        if (j_q == nm1_q) begin
          state_d = ST_LAST;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_LAST: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (lt_q <= klo_q && klo_q < le_q) begin
          lo_d = cand_q;
        end
        if (lt_q <= khi_q && khi_q < le_q) begin
          hi_d = cand_q;
        end
        lt_d = '0;
        le_d = '0;
        j_d  = '0;
        if (i_q == nm1_q) begin
          state_d = ST_SUM;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SUM: begin
        num_d   = NUM_W'(sum_s) * NUM_W'(ddmf_pkg::CENTI) + NUM_W'(DENOM);
        acc_d   = '0;
        rcp_d   = RCP_PAD_W'(RECIP);
        dc_d    = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // reciprocal taken 16 bits at a time, top part first
        acc_d = (acc_q << CHUNK_W) + ACC_W'(part);
        rcp_d = rcp_q << CHUNK_W;
        dc_d  = dc_q + DC_W'(1);
        if (dc_q == DC_W'(N_CHUNK - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_vld_q || result_o.ready) begin
          res_d     = ddmf_pkg::DENSITY_W'(acc_q >> DIV_SH);
          res_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sum_q     <= '0;
      cnt_q     <= '0;
      wp_q      <= '0;
      full_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      wp_q      <= wp_d;
      full_q    <= full_d;
      cmp_vld_q <= cmp_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sub_q  <= sub_d;
    nm1_q  <= nm1_d;
    klo_q  <= klo_d;
    khi_q  <= khi_d;
    i_q    <= i_d;
    j_q    <= j_d;
    lt_q   <= lt_d;
    le_q   <= le_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    num_q  <= num_d;
    acc_q  <= acc_d;
    rcp_q  <= rcp_d;
    dc_q   <= dc_d;
    res_q  <= res_d;
  end

endmodule

// ===== hw/rtl/ddmf_checker.sv =====
// ddmf_port_checker: port-level assertions for dust_density_median_filter, bound to the top level
// depends on ddmf_pkg for the result width

module ddmf_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           sample_valid,
  input logic                           sample_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [ddmf_pkg::DENSITY_W-1:0] result_data
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("stalled result word changed");

  // sample side stalls only after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sample_ready) |-> $past(sample_valid && sample_ready))
    else $error("sample ready dropped without a taken word");

  // a new result appears only at the end of a busy phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid) |-> sample_ready && !$past(sample_ready))
    else $error("result appeared outside the end of a group");

  // no result appears while the sample side stays ready after a taken word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid && sample_ready ##1 sample_ready |-> !$rose(result_valid))
    else $error("result appeared without a group end");

endmodule

bind dust_density_median_filter ddmf_port_checker u_ddmf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .sample_valid (sample_i.valid),
  .sample_ready (sample_i.ready),
  .result_valid (result_o.valid),
  .result_ready (result_o.ready),
  .result_data  (result_o.density_centi)
);
